[rtl/fcsb_pkg.sv]
// Shared constants, item type and helpers for the frustum culling block.
`timescale 1ns / 1ps
`default_nettype none

package fcsb_pkg;

    localparam int NUM_PLANES       = 6;
    localparam int COORD_WIDTH      = 32;
    localparam int NORMAL_FRAC_BITS = 14;

    localparam int IN_W       = 32;
    localparam int RADIUS_W   = 31;
    localparam int MODE_W     = 2;
    localparam int INDEX_W    = 3;
    localparam int COORD_IN_W = (COORD_WIDTH < IN_W) ? COORD_WIDTH : IN_W;
    localparam int NORMAL_W   = NORMAL_FRAC_BITS + 2;
    localparam int DIFF_W     = COORD_IN_W + 1;
    localparam int PROD_W     = DIFF_W + NORMAL_W;
    localparam int SUM_W      = PROD_W + 3;
    localparam int BIAS_W     = RADIUS_W + NORMAL_FRAC_BITS + 2;
    localparam int ACC_W      = (SUM_W > BIAS_W) ? SUM_W : BIAS_W;
    localparam int CELL_ID_W  = ($clog2(NUM_PLANES) > INDEX_W) ? $clog2(NUM_PLANES) : INDEX_W;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPHERE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOX    = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [INDEX_W-1:0]  plane_index;
        logic [IN_W-1:0]     first_x;
        logic [IN_W-1:0]     first_y;
        logic [IN_W-1:0]     first_z;
        logic [IN_W-1:0]     second_x;
        logic [IN_W-1:0]     second_y;
        logic [IN_W-1:0]     second_z;
        logic [RADIUS_W-1:0] radius;
        logic                visible;
    } item_t;

    function automatic logic is_test(input logic [MODE_W-1:0] mode);
        return (mode == MODE_SPHERE) || (mode == MODE_BOX);
    endfunction

endpackage

`default_nettype wire

[rtl/fcsb_cell.sv]
// One plane cell: holds a plane and tests each passing word against it in three stages.
`timescale 1ns / 1ps
`default_nettype none

module fcsb_cell (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           adv,
    input  wire logic [fcsb_pkg::CELL_ID_W-1:0] cell_id,
    input  wire logic                           in_valid,
    input  wire fcsb_pkg::item_t                in_item,
    output logic                                out_valid,
    output fcsb_pkg::item_t                     out_item
);
    import fcsb_pkg::*;

    logic signed [COORD_IN_W-1:0] pt_x_reg, pt_y_reg, pt_z_reg;
    logic signed [NORMAL_W-1:0]   nx_reg, ny_reg, nz_reg;

    logic signed [COORD_IN_W-1:0] fx, fy, fz, sx, sy, sz, cx, cy, cz;
    logic signed [DIFF_W-1:0]     dx_next, dy_next, dz_next;
    logic                         is_box, load_hit;

    logic                         v0_reg, v1_reg, v2_reg;
    item_t                        it0_reg, it1_reg, it2_reg, it2_next;
    logic signed [DIFF_W-1:0]     dx0_reg, dy0_reg, dz0_reg;
    logic signed [NORMAL_W-1:0]   nx0_reg, ny0_reg, nz0_reg;
    logic signed [PROD_W-1:0]     px_next, py_next, pz_next;
    logic signed [PROD_W-1:0]     px1_reg, py1_reg, pz1_reg;
    logic signed [ACC_W-1:0]      bias, acc;

    assign fx = in_item.first_x[COORD_IN_W-1:0];
    assign fy = in_item.first_y[COORD_IN_W-1:0];
    assign fz = in_item.first_z[COORD_IN_W-1:0];
    assign sx = in_item.second_x[COORD_IN_W-1:0];
    assign sy = in_item.second_y[COORD_IN_W-1:0];
    assign sz = in_item.second_z[COORD_IN_W-1:0];

    assign is_box   = (in_item.mode == MODE_BOX);
    assign load_hit = in_valid && adv && (in_item.mode == MODE_LOAD)
                      && (CELL_ID_W'(in_item.plane_index) == cell_id);

    // A box uses its far corner along the plane normal; a sphere uses its center.
    assign cx = (is_box && (nx_reg > 0)) ? sx : fx;
    assign cy = (is_box && (ny_reg > 0)) ? sy : fy;
    assign cz = (is_box && (nz_reg > 0)) ? sz : fz;

    assign dx_next = DIFF_W'(cx) - DIFF_W'(pt_x_reg);
    assign dy_next = DIFF_W'(cy) - DIFF_W'(pt_y_reg);
    assign dz_next = DIFF_W'(cz) - DIFF_W'(pt_z_reg);

    assign px_next = PROD_W'(nx0_reg) * PROD_W'(dx0_reg);
    assign py_next = PROD_W'(ny0_reg) * PROD_W'(dy0_reg);
    assign pz_next = PROD_W'(nz0_reg) * PROD_W'(dz0_reg);

    always_comb begin
        bias = '0;
        if (it1_reg.mode == MODE_SPHERE) begin
            bias = ACC_W'(it1_reg.radius) << NORMAL_FRAC_BITS;
        end
        acc = ACC_W'(px1_reg) + ACC_W'(py1_reg) + ACC_W'(pz1_reg) + bias;
        it2_next = it1_reg;
        if (is_test(it1_reg.mode) && acc[ACC_W-1]) begin
            it2_next.visible = 1'b0;
        end
    end

    // The plane is written as the load word enters, so later words see it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_x_reg <= '0;
            pt_y_reg <= '0;
            pt_z_reg <= '0;
            nx_reg   <= '0;
            ny_reg   <= '0;
            nz_reg   <= '0;
        end else if (load_hit) begin
            pt_x_reg <= fx;
            pt_y_reg <= fy;
            pt_z_reg <= fz;
            nx_reg   <= in_item.second_x[NORMAL_W-1:0];
            ny_reg   <= in_item.second_y[NORMAL_W-1:0];
            nz_reg   <= in_item.second_z[NORMAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // Normals travel with the differences so a later load cannot disturb this word.
    always_ff @(posedge aclk) begin
        if (adv) begin
            it0_reg <= in_item;
            dx0_reg <= dx_next;
            dy0_reg <= dy_next;
            dz0_reg <= dz_next;
            nx0_reg <= nx_reg;
            ny0_reg <= ny_reg;
            nz0_reg <= nz_reg;
            it1_reg <= it0_reg;
            px1_reg <= px_next;
            py1_reg <= py_next;
            pz1_reg <= pz_next;
            it2_reg <= it2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = it2_reg;

endmodule

`default_nettype wire

[rtl/frustum_cull_sphere_box.sv]
// Frustum culling engine: top level with the plane cell chain and the output register.
`timescale 1ns / 1ps
`default_nettype none

// Tests spheres and axis-aligned boxes against NUM_PLANES frustum planes at one word per
// cycle. Each plane lives in a cell of a chain; a word passes through every cell, and each
// cell subtracts, then multiplies, then sums and compares; the last cell feeds the output
// register. A load word writes its plane as it passes that plane's cell and gives no
// result, nor does mode 3. The whole chain stalls only while the output register holds a
// word that is not taken.
module frustum_cull_sphere_box (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [fcsb_pkg::MODE_W-1:0]    s_mode,
    input  wire logic [fcsb_pkg::INDEX_W-1:0]   s_plane_index,
    input  wire logic signed [fcsb_pkg::IN_W-1:0] s_first_x,
    input  wire logic signed [fcsb_pkg::IN_W-1:0] s_first_y,
    input  wire logic signed [fcsb_pkg::IN_W-1:0] s_first_z,
    input  wire logic signed [fcsb_pkg::IN_W-1:0] s_second_x,
    input  wire logic signed [fcsb_pkg::IN_W-1:0] s_second_y,
    input  wire logic signed [fcsb_pkg::IN_W-1:0] s_second_z,
    input  wire logic [fcsb_pkg::RADIUS_W-1:0]  s_sphere_radius,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_inside_res
);
    import fcsb_pkg::*;

    logic  adv;
    logic  chain_valid [0:NUM_PLANES];
    item_t chain_item  [0:NUM_PLANES];
    logic  tail_valid, tail_is_test;
    item_t tail_item;
    logic  m_valid_reg, m_inside_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_comb begin
        chain_item[0]             = '0;
        chain_item[0].mode        = s_mode;
        chain_item[0].plane_index = s_plane_index;
        chain_item[0].first_x     = s_first_x;
        chain_item[0].first_y     = s_first_y;
        chain_item[0].first_z     = s_first_z;
        chain_item[0].second_x    = s_second_x;
        chain_item[0].second_y    = s_second_y;
        chain_item[0].second_z    = s_second_z;
        chain_item[0].radius      = s_sphere_radius;
        chain_item[0].visible     = 1'b1;
    end
    assign chain_valid[0] = s_valid;

    for (genvar i = 0; i < NUM_PLANES; i++) begin : g_plane
        fcsb_cell u_plane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .cell_id   (CELL_ID_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_item   (chain_item[i]),
            .out_valid (chain_valid[i+1]),
            .out_item  (chain_item[i+1])
        );
    end

    assign tail_valid   = chain_valid[NUM_PLANES];
    assign tail_item    = chain_item[NUM_PLANES];
    assign tail_is_test = is_test(tail_item.mode);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= tail_valid && tail_is_test;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_inside_reg <= tail_item.visible;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = m_inside_reg;

    a_tail_to_output : assert property (@(posedge aclk) disable iff (!aresetn)
        (tail_valid && tail_is_test && adv) |=>
            (m_valid && (m_inside_res == $past(tail_item.visible))))
        else $error("test word at the chain tail did not reach the output");

    a_output_source : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(tail_valid && tail_is_test))
        else $error("output word appeared without a test word at the chain tail");

    a_reset_clears : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid set after reset");

endmodule

`default_nettype wire

[tb/tb_frustum_cull_sphere_box.sv]
// Self-checking testbench for the frustum culling block: plane loads, sphere and box tests.
`timescale 1ns / 1ps

module tb_frustum_cull_sphere_box;
    import fcsb_pkg::*;

    localparam int PIPE_LAT    = 3 * NUM_PLANES + 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [MODE_W-1:0]      s_mode = MODE_LOAD;
    logic [INDEX_W-1:0]     s_plane_index = '0;
    logic signed [IN_W-1:0] s_first_x = '0;
    logic signed [IN_W-1:0] s_first_y = '0;
    logic signed [IN_W-1:0] s_first_z = '0;
    logic signed [IN_W-1:0] s_second_x = '0;
    logic signed [IN_W-1:0] s_second_y = '0;
    logic signed [IN_W-1:0] s_second_z = '0;
    logic [RADIUS_W-1:0]    s_sphere_radius = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_inside_res;

    // Plane store as the block should hold it, widened to exact integers.
    longint pt_x[NUM_PLANES] = '{default: 0};
    longint pt_y[NUM_PLANES] = '{default: 0};
    longint pt_z[NUM_PLANES] = '{default: 0};
    longint nrm_x[NUM_PLANES] = '{default: 0};
    longint nrm_y[NUM_PLANES] = '{default: 0};
    longint nrm_z[NUM_PLANES] = '{default: 0};

    logic        inside_expected[$];
    logic        want;
    int          fail_count = 0;
    int          n_loads = 0;
    int          n_spheres = 0;
    int          n_boxes = 0;
    int          n_inside = 0;
    int          n_culled = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;

    frustum_cull_sphere_box i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_plane_index   (s_plane_index),
        .s_first_x       (s_first_x),
        .s_first_y       (s_first_y),
        .s_first_z       (s_first_z),
        .s_second_x      (s_second_x),
        .s_second_y      (s_second_y),
        .s_second_z      (s_second_z),
        .s_sphere_radius (s_sphere_radius),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_inside_res    (m_inside_res)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout: %0d results still outstanding.", inside_expected.size());
            $display("frustum_cull_sphere_box: mismatch");
            $finish;
        end
    end

    // The receiver drops ready at random, for a random length of stall held in stall_left.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (m_ready && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (inside_expected.size() == 0) begin
                $error("inside_res: no word expected, got %0b", m_inside_res);
                fail_count++;
            end else begin
                want = inside_expected.pop_front();
                if (m_inside_res !== want) begin
                    $error("inside_res: expected %0b, got %0b", want, m_inside_res);
                    fail_count++;
                end
                if (want) n_inside++;
                else n_culled++;
            end
        end
    end

    function automatic longint sext_to(logic [IN_W-1:0] v, int w);
        longint t;
        t = longint'(v) <<< (64 - w);
        return t >>> (64 - w);
    endfunction

    function automatic longint plane_distance(int p, longint x, longint y, longint z);
        return nrm_x[p] * (x - pt_x[p]) + nrm_y[p] * (y - pt_y[p]) + nrm_z[p] * (z - pt_z[p]);
    endfunction

    // Applies one accepted word to the plane store and queues the verdict of a test word.
    task automatic predict_inside(input item_t w);
        longint fx, fy, fz, sx, sy, sz, lim, cx, cy, cz;
        logic   visible;
        fx = sext_to(w.first_x, COORD_IN_W);
        fy = sext_to(w.first_y, COORD_IN_W);
        fz = sext_to(w.first_z, COORD_IN_W);
        sx = sext_to(w.second_x, COORD_IN_W);
        sy = sext_to(w.second_y, COORD_IN_W);
        sz = sext_to(w.second_z, COORD_IN_W);
        visible = 1'b1;
        case (w.mode)
            MODE_LOAD: begin
                n_loads++;
                if (w.plane_index < NUM_PLANES) begin
                    pt_x[w.plane_index] = fx;
                    pt_y[w.plane_index] = fy;
                    pt_z[w.plane_index] = fz;
                    nrm_x[w.plane_index] = sext_to(w.second_x, NORMAL_W);
                    nrm_y[w.plane_index] = sext_to(w.second_y, NORMAL_W);
                    nrm_z[w.plane_index] = sext_to(w.second_z, NORMAL_W);
                end
            end
            MODE_SPHERE: begin
                lim = -(longint'(w.radius) <<< NORMAL_FRAC_BITS);
                for (int p = 0; p < NUM_PLANES; p++) begin
                    if (plane_distance(p, fx, fy, fz) < lim) visible = 1'b0;
                end
                inside_expected.push_back(visible);
                n_spheres++;
            end
            MODE_BOX: begin
                for (int p = 0; p < NUM_PLANES; p++) begin
                    cx = (nrm_x[p] > 0) ? sx : fx;
                    cy = (nrm_y[p] > 0) ? sy : fy;
                    cz = (nrm_z[p] > 0) ? sz : fz;
                    if (plane_distance(p, cx, cy, cz) < 0) visible = 1'b0;
                end
                inside_expected.push_back(visible);
                n_boxes++;
            end
            default: ;
        endcase
    endtask

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_word(input item_t w);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= w.mode;
        s_plane_index   <= w.plane_index;
        s_first_x       <= w.first_x;
        s_first_y       <= w.first_y;
        s_first_z       <= w.first_z;
        s_second_x      <= w.second_x;
        s_second_y      <= w.second_y;
        s_second_z      <= w.second_z;
        s_sphere_radius <= w.radius;
        do @(posedge aclk); while (!s_ready);
        predict_inside(w);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (inside_expected.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 4) @(posedge aclk);
    endtask

    function automatic item_t plane_word(int idx, int px, int py, int pz,
                                         logic [31:0] nx, logic [31:0] ny, logic [31:0] nz);
        item_t w;
        w = '0;
        w.mode = MODE_LOAD;
        w.plane_index = INDEX_W'(idx);
        w.first_x = px;
        w.first_y = py;
        w.first_z = pz;
        w.second_x = nx;
        w.second_y = ny;
        w.second_z = nz;
        return w;
    endfunction

    function automatic item_t sphere_word(int x, int y, int z, logic [RADIUS_W-1:0] r);
        item_t w;
        w = '0;
        w.mode = MODE_SPHERE;
        w.plane_index = INDEX_W'($urandom_range(0, 7));
        w.first_x = x;
        w.first_y = y;
        w.first_z = z;
        w.second_x = $urandom;
        w.radius = r;
        return w;
    endfunction

    function automatic item_t box_word(int x0, int y0, int z0, int x1, int y1, int z1);
        item_t w;
        w = '0;
        w.mode = MODE_BOX;
        w.plane_index = INDEX_W'($urandom_range(0, 7));
        w.first_x = x0;
        w.first_y = y0;
        w.first_z = z0;
        w.second_x = x1;
        w.second_y = y1;
        w.second_z = z1;
        w.radius = RADIUS_W'($urandom);
        return w;
    endfunction

    function automatic item_t raw_word();
        item_t w;
        w.mode = MODE_W'($urandom_range(0, 3));
        w.plane_index = INDEX_W'($urandom_range(0, 7));
        w.first_x = $urandom;
        w.first_y = $urandom;
        w.first_z = $urandom;
        w.second_x = $urandom;
        w.second_y = $urandom;
        w.second_z = $urandom;
        w.radius = RADIUS_W'($urandom);
        w.visible = 1'b0;
        return w;
    endfunction

    // Words that must not disturb a loaded frustum: unused mode, loads past the last
    // plane, and tests with coordinates anywhere in the full range.
    function automatic item_t noise_word();
        item_t w;
        w = raw_word();
        case ($urandom_range(0, 2))
            0: w.mode = MODE_UNUSED;
            1: begin
                w.mode = MODE_LOAD;
                w.plane_index = INDEX_W'($urandom_range(NUM_PLANES, 7));
            end
            default: w.mode = $urandom_range(0, 1) ? MODE_SPHERE : MODE_BOX;
        endcase
        return w;
    endfunction

    function automatic int offset(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Places a normal component in the low bits and fills the bits above with junk.
    function automatic logic [31:0] with_junk(int n);
        logic [31:0] r;
        r = $urandom;
        r[NORMAL_W-1:0] = n[NORMAL_W-1:0];
        return r;
    endfunction

    function automatic int unsigned pick_idle();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 40;
        endcase
    endfunction

    task automatic test_unloaded_planes();
        idle_pct = 20;
        send_word(sphere_word(32'h8000_0000, 32'h7FFF_FFFF, 0, '0));
        send_word(box_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_word(sphere_word(0, 0, 0, '1));
    endtask

    task automatic test_ignored_words();
        item_t w;
        w = raw_word();
        w.mode = MODE_UNUSED;
        send_word(w);
        send_word(plane_word(6, 0, 0, 0, 32'h0000_4000, 0, 0));
        send_word(plane_word(7, 0, 0, 0, 32'h0000_C000, 32'h0000_4000, 0));
        send_word(sphere_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0));
    endtask

    task automatic test_plane_extremes();
        send_word(plane_word(0, 0, 0, 0, 32'hABCD_7FFF, 32'h0000_8000, 32'hFFFF_0000));
        send_word(plane_word(NUM_PLANES - 1, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                             0, 0, 32'h0000_4000));
        send_word(sphere_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0));
        send_word(sphere_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '1));
        send_word(box_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        // An inverted box is taken as given.
        send_word(box_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    endtask

    // One plane facing +x through x = 1.0; the distance lands exactly on the limit.
    task automatic test_boundaries();
        send_word(plane_word(0, 0, 0, 0, 0, 0, 0));
        send_word(plane_word(NUM_PLANES - 1, 0, 0, 0, 0, 0, 0));
        send_word(plane_word(1, 1 << 16, 0, 0, 32'h0000_4000, 0, 0));
        send_word(sphere_word(-(4 << 16), 7, -3, RADIUS_W'(5 << 16)));
        send_word(sphere_word(-(4 << 16) - 1, 7, -3, RADIUS_W'(5 << 16)));
        send_word(box_word(-(10 << 16), 0, 0, 1 << 16, 1, 1));
        send_word(box_word(-(10 << 16), 0, 0, (1 << 16) - 1, 1, 1));
    endtask

    // Loads an axis-aligned frustum with jittered normals and tests volumes around it.
    task automatic test_random_frustums(input int n_sets, input int n_tests, input bit calm);
        int ctr[3];
        int pt[3];
        int nrm[3];
        int lo[3];
        int hi[3];
        int half;
        int ax;
        for (int s = 0; s < n_sets; s++) begin
            idle_pct = calm ? 0 : pick_idle();
            half = $urandom_range(1, 50) << 16;
            foreach (ctr[k]) ctr[k] = offset(20 << 16);
            for (int p = 0; p < NUM_PLANES; p++) begin
                ax = p % 3;
                pt = ctr;
                foreach (nrm[k]) nrm[k] = offset(1000);
                pt[ax] = ctr[ax] + ((p < 3) ? -half : half);
                nrm[ax] = (p < 3) ? 16384 : -16384;
                send_word(plane_word(p, pt[0], pt[1], pt[2],
                                     with_junk(nrm[0]), with_junk(nrm[1]), with_junk(nrm[2])));
            end
            for (int t = 0; t < n_tests; t++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_word(noise_word());
                end else if ($urandom_range(0, 1)) begin
                    send_word(sphere_word(ctr[0] + offset(half + half / 2),
                                          ctr[1] + offset(half + half / 2),
                                          ctr[2] + offset(half + half / 2),
                                          RADIUS_W'($urandom_range(0, half))));
                end else begin
                    foreach (lo[k]) begin
                        lo[k] = ctr[k] + offset(half + half / 2);
                        hi[k] = lo[k] + int'($urandom_range(0, half));
                        if ($urandom_range(0, 7) == 0) hi[k] = lo[k] - (hi[k] - lo[k]) - 1;
                    end
                    send_word(box_word(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]));
                end
            end
        end
    endtask

    task automatic test_random_noise(input int n_words);
        idle_pct = 25;
        for (int i = 0; i < n_words; i++) send_word(raw_word());
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_unloaded_planes();
        test_ignored_words();
        test_plane_extremes();
        test_boundaries();
        test_random_frustums(4, 30, 1'b0);
        wait_drained();
        test_random_frustums(4, 30, 1'b0);
        test_random_noise(60);
        test_random_frustums(2, 30, 1'b1);
        wait_drained();
        $display("Run covered %0d plane loads, %0d sphere and %0d box tests.",
                 n_loads, n_spheres, n_boxes);
        $display("Verdicts seen: %0d inside, %0d culled.", n_inside, n_culled);
        if (fail_count == 0) begin
            $display("frustum_cull_sphere_box: match");
        end else begin
            $display("frustum_cull_sphere_box: mismatch");
        end
        $finish;
    end

endmodule
